[rtl/core/pitot_pkg.sv]
`default_nettype none
package pitot_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CONV_FACTOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CORR_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CORR_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_ENABLE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_OFFSET = 3'd6;

	// field types
	typedef logic        [15:0] volt_t;
	typedef logic        [15:0] rspeed_t;
	typedef logic        [15:0] gain_t;
	typedef logic signed [15:0] soffs_t;
	typedef logic signed [17:0] pres_t;
	typedef logic signed [17:0] speed_t;

	localparam speed_t SPEED_MAX   = 18'sh1FFFF;
	localparam speed_t SPEED_MIN   = 18'sh20000;
	localparam pres_t  PRES_FLOOR  = 18'sh20000;

	// register reset values
	localparam gain_t  CONV_FACTOR_RST = 16'd6687;
	localparam gain_t  CORR_GAIN_RST   = 16'd4096;
	localparam soffs_t CORR_OFFSET_RST = 16'sd0;
	localparam gain_t  FILTER_GAIN_RST = 16'd0;
	localparam gain_t  CAL_GAIN_RST    = 16'd0;
	localparam logic   CAL_ENABLE_RST  = 1'b1;

endpackage
`default_nettype wire

[rtl/core/pitot_airspeed_estimator_top.sv]
// pitot airspeed estimator: takes one averaged sensor voltage word (1/8192 V) with a warmed-up
// flag and returns one result word: offset-corrected differential pressure, square-root airspeed,
// gain/offset corrected airspeed and the smoothed airspeed before and after this word. the block
// works on one word at a time under a small sequencer; in_ready is high only while it is idle,
// and a finished result sits in an output register so the next word can be taken while it waits.
// the 16-step restoring square root and the 17-step restoring divide both run on one shared
// 20-bit subtractor and dominate the time per word, one shared 17x19 multiplier serves the
// offset filter, the pressure-to-speed factor and the speed filter (product registered). the
// root is skipped when the radicand saturates the speed, the divide is skipped when the
// quotient saturates or the numerator is zero, and both filters are skipped while not warmed
// up. configuration words go in on their own channel at any time the block is idle; a write of
// the initial pressure offset also loads the running offset, clamped to the pressure range.
// unknown indexes are ignored.
`default_nettype none
module pitot_airspeed_estimator_top
	import pitot_pkg::*;
#(
	parameter int PRESSURE_FRAC_BITS = 4,
	parameter int SPEED_FRAC_BITS    = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// configuration channel
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data,
	// sample channel
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [15:0]           voltage,
	input  wire                   warmed_up,
	// result channel
	output logic                  out_valid,
	input  wire                   out_ready,
	output pres_t                 pressure_delta,
	output rspeed_t               root_speed,
	output speed_t                corrected_speed,
	output speed_t                filtered_airspeed,
	output speed_t                previous_airspeed
);

	// pressure scaling
	localparam int P_SCALED = 5000 << PRESSURE_FRAC_BITS;
	localparam int P_LIM    = (P_SCALED > 131071) ? 131071 : P_SCALED;
	localparam int P_ZERO   = 2500 << PRESSURE_FRAC_BITS;
	localparam int RP_W     = PRESSURE_FRAC_BITS + 27;
	localparam int RF_W     = PRESSURE_FRAC_BITS + 16;
	localparam logic signed [RF_W-1:0] RF_HI   = RF_W'(P_LIM);
	localparam logic signed [RF_W-1:0] RF_LO   = RF_W'(-P_LIM);
	localparam logic signed [RF_W-1:0] RF_ZERO = RF_W'(P_ZERO);
	localparam pres_t P_HI = pres_t'(P_LIM);
	localparam pres_t P_LO = pres_t'(-P_LIM);

	// radicand alignment: pressure fraction plus q4.12 factor to squared speed fraction
	localparam int SH    = 2 * SPEED_FRAC_BITS - PRESSURE_FRAC_BITS - 12;
	localparam int SHL   = (SH > 0) ? SH : 0;
	localparam int SHR   = (SH < 0) ? -SH : 0;
	localparam int RAD_W = 33 + SHL;

	localparam logic [4:0] SQRT_LAST = 5'd15;
	localparam logic [4:0] DIV_LAST  = 5'd16;

	// sequencer states
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_RAW      = 4'd1;
	localparam logic [3:0] ST_OFF_MUL  = 4'd2;
	localparam logic [3:0] ST_OFF_ADD  = 4'd3;
	localparam logic [3:0] ST_DIFF     = 4'd4;
	localparam logic [3:0] ST_RAD_MUL  = 4'd5;
	localparam logic [3:0] ST_RAD_CHK  = 4'd6;
	localparam logic [3:0] ST_SQRT     = 4'd7;
	localparam logic [3:0] ST_DIV_PREP = 4'd8;
	localparam logic [3:0] ST_DIV_CHK  = 4'd9;
	localparam logic [3:0] ST_DIV      = 4'd10;
	localparam logic [3:0] ST_DIV_FIN  = 4'd11;
	localparam logic [3:0] ST_FLT_MUL  = 4'd12;
	localparam logic [3:0] ST_FLT_ADD  = 4'd13;
	localparam logic [3:0] ST_DONE     = 4'd14;

	// saturate a 21-bit signed value to [lo, hi]
	function automatic logic signed [17:0] clamp21(input logic signed [20:0] x,
			input logic signed [17:0] lo, input logic signed [17:0] hi);
		logic signed [17:0] r;
		if (x > 21'(hi)) begin
			r = hi;
		end else if (x < 21'(lo)) begin
			r = lo;
		end else begin
			r = x[17:0];
		end
		return r;
	endfunction

	// configuration registers
	gain_t  conv_q;
	gain_t  gain_q;
	soffs_t coff_q;
	gain_t  filt_gain_q;
	gain_t  cal_gain_q;
	logic   cal_en_q;

	// sequencer and kept state
	logic [3:0] state_q;
	logic [4:0] cnt_q;
	pres_t      off_q;
	speed_t     smooth_q;
	speed_t     prior_q;
	logic       out_valid_q;

	// working registers
	volt_t               v_q;
	logic                warm_q;
	pres_t               raw_q;
	pres_t               diff_q;
	logic signed [35:0]  prod_q;
	logic [31:0]         rad_q;
	logic [19:0]         rem_q;
	logic [15:0]         root_q;
	rspeed_t             speed_q;
	logic [16:0]         num_q;
	logic                neg_q;
	logic                zero_q;
	logic                sat_q;
	speed_t              scaled_q;

	// result register
	pres_t   dp_q;
	rspeed_t rs_q;
	speed_t  ss_q;
	speed_t  fs_q;
	speed_t  ps_q;

	// combinational datapath
	logic [RP_W-1:0]         rp_prod;
	logic [RP_W-1:0]         rp_round;
	logic [RP_W-1:0]         rp_shr;
	logic signed [RF_W-1:0]  rf;
	pres_t                   raw_new;

	logic signed [16:0]      mul_a;
	logic signed [18:0]      mul_b;
	logic signed [35:0]      mul_p;

	logic signed [17:0]      blend_base;
	logic signed [36:0]      blend_sum;
	logic signed [17:0]      blend_sat;

	logic signed [18:0]      diff_full;
	pres_t                   diff_sat;
	logic [17:0]             diff_neg;
	logic [16:0]             pres_mag;

	logic [RAD_W-1:0]        rad_full;
	logic                    rad_ovf;

	logic [19:0]             sub_a;
	logic [19:0]             sub_b;
	logic [20:0]             sub_d;
	logic                    borrow;
	logic [15:0]             root_nxt;

	logic signed [17:0]      sdiff;
	logic [17:0]             sneg;
	logic [16:0]             smag;
	logic [17:0]             quot;
	logic [17:0]             quot_neg;
	speed_t                  scaled_new;

	logic                    accept;
	logic                    out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// raw pressure: round(v * 1000 * 2^pf / 8192) minus the 2.5 kpa zero point
	always_comb begin
		rp_prod  = RP_W'(v_q) * RP_W'(1000);
		rp_round = (rp_prod << PRESSURE_FRAC_BITS) + RP_W'(4096);
		rp_shr   = rp_round >> 13;
		rf       = $signed({2'b00, rp_shr[PRESSURE_FRAC_BITS+13:0]}) - RF_ZERO;
		if (rf > RF_HI) begin
			raw_new = P_HI;
		end else if (rf < RF_LO) begin
			raw_new = P_LO;
		end else begin
			raw_new = pres_t'(rf);
		end
	end

	// offset-corrected pressure and its magnitude
	always_comb begin
		diff_full = {raw_q[17], raw_q} - {off_q[17], off_q};
		diff_sat  = clamp21(21'(diff_full), P_LO, P_HI);
		diff_neg  = -diff_q;
		pres_mag  = diff_q[17] ? diff_neg[16:0] : diff_q[16:0];
	end

	// shared multiplier; the filters use new + g*(old-new) form, one product each
	always_comb begin
		case (state_q)
			ST_OFF_MUL: begin
				mul_a = {1'b0, cal_gain_q};
				mul_b = {off_q[17], off_q} - {raw_q[17], raw_q};
			end
			ST_RAD_MUL: begin
				mul_a = {1'b0, conv_q};
				mul_b = {2'b00, pres_mag};
			end
			ST_FLT_MUL: begin
				mul_a = {1'b0, filt_gain_q};
				mul_b = {smooth_q[17], smooth_q} - {scaled_q[17], scaled_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// blend: floor((new * 65536 + g * (old - new) + 32768) / 65536), then saturate
	always_comb begin
		blend_base = (state_q == ST_OFF_ADD) ? raw_q : scaled_q;
		blend_sum  = {{3{blend_base[17]}}, blend_base, 16'h0000} + {prod_q[35], prod_q}
			+ 37'sd32768;
		if (state_q == ST_OFF_ADD) begin
			blend_sat = clamp21($signed(blend_sum[36:16]), P_LO, P_HI);
		end else begin
			blend_sat = clamp21($signed(blend_sum[36:16]), SPEED_MIN, SPEED_MAX);
		end
	end

	// radicand in squared speed units; at or above 2^32 the root saturates
	always_comb begin
		rad_full = (RAD_W'(prod_q[32:0]) << SHL) >> SHR;
		rad_ovf  = |rad_full[RAD_W-1:32];
	end

	// shared subtractor for root and divide steps
	always_comb begin
		case (state_q)
			ST_SQRT: begin
				sub_a = {rem_q[17:0], rad_q[31:30]};
				sub_b = {2'b00, root_q, 2'b01};
			end
			ST_DIV_CHK: begin
				sub_a = rem_q;
				sub_b = {4'h0, gain_q};
			end
			ST_DIV: begin
				sub_a = {rem_q[18:0], num_q[16]};
				sub_b = {4'h0, gain_q};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
		sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
		borrow   = sub_d[20];
		root_nxt = {root_q[14:0], !borrow};
	end

	// corrected speed: sign and magnitude of (raw - offset), quotient by gain
	always_comb begin
		sdiff    = {2'b00, speed_q} - {{2{coff_q[15]}}, coff_q};
		sneg     = -sdiff;
		smag     = sdiff[17] ? sneg[16:0] : sdiff[16:0];
		quot     = {1'b0, num_q};
		quot_neg = -quot;
		if (zero_q) begin
			scaled_new = '0;
		end else if (sat_q) begin
			scaled_new = neg_q ? SPEED_MIN : SPEED_MAX;
		end else begin
			scaled_new = neg_q ? quot_neg : quot;
		end
	end

	// sequencer, configuration and kept state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			off_q       <= '0;
			smooth_q    <= '0;
			prior_q     <= '0;
			out_valid_q <= 1'b0;
			conv_q      <= CONV_FACTOR_RST;
			gain_q      <= CORR_GAIN_RST;
			coff_q      <= CORR_OFFSET_RST;
			filt_gain_q <= FILTER_GAIN_RST;
			cal_gain_q  <= CAL_GAIN_RST;
			cal_en_q    <= CAL_ENABLE_RST;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_CONV_FACTOR: conv_q      <= cfg_data[15:0];
					REG_CORR_GAIN:   gain_q      <= cfg_data[15:0];
					REG_CORR_OFFSET: coff_q      <= cfg_data[15:0];
					REG_FILTER_GAIN: filt_gain_q <= cfg_data[15:0];
					REG_CAL_GAIN:    cal_gain_q  <= cfg_data[15:0];
					REG_CAL_ENABLE:  cal_en_q    <= cfg_data[0];
					REG_INIT_OFFSET: off_q       <= clamp21(21'($signed(cfg_data)), P_LO, P_HI);
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RAW;
					end
				end
				ST_RAW: begin
					// offset calibration only while enabled and warmed up
					state_q <= (cal_en_q && warm_q) ? ST_OFF_MUL : ST_DIFF;
				end
				ST_OFF_MUL: state_q <= ST_OFF_ADD;
				ST_OFF_ADD: begin
					off_q   <= blend_sat;
					state_q <= ST_DIFF;
				end
				ST_DIFF:    state_q <= ST_RAD_MUL;
				ST_RAD_MUL: state_q <= ST_RAD_CHK;
				ST_RAD_CHK: begin
					if (rad_ovf) begin
						state_q <= ST_DIV_PREP;
					end else begin
						cnt_q   <= SQRT_LAST;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV_PREP;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_DIV_PREP: state_q <= ST_DIV_CHK;
				ST_DIV_CHK: begin
					// zero numerator or quotient of 2^17 and up needs no divide
					if (zero_q || !borrow) begin
						state_q <= ST_DIV_FIN;
					end else begin
						cnt_q   <= DIV_LAST;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV_FIN;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_DIV_FIN: state_q <= warm_q ? ST_FLT_MUL : ST_DONE;
				ST_FLT_MUL: state_q <= ST_FLT_ADD;
				ST_FLT_ADD: begin
					prior_q  <= smooth_q;
					smooth_q <= blend_sat;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					v_q    <= voltage;
					warm_q <= warmed_up;
				end
			end
			ST_RAW:     raw_q  <= raw_new;
			ST_OFF_MUL: prod_q <= mul_p;
			ST_DIFF:    diff_q <= diff_sat;
			ST_RAD_MUL: prod_q <= mul_p;
			ST_RAD_CHK: begin
				if (rad_ovf) begin
					speed_q <= '1;
				end else begin
					rad_q  <= rad_full[31:0];
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				// one root bit per step, two radicand bits shifted in
				rad_q  <= {rad_q[29:0], 2'b00};
				rem_q  <= borrow ? sub_a : sub_d[19:0];
				root_q <= root_nxt;
				if (cnt_q == '0) begin
					speed_q <= root_nxt;
				end
			end
			ST_DIV_PREP: begin
				// dividend is |raw - offset| * 4096, upper 12 bits start the remainder
				neg_q  <= sdiff[17];
				zero_q <= (sdiff == '0);
				num_q  <= {smag[4:0], 12'h000};
				rem_q  <= {8'h00, smag[16:5]};
			end
			ST_DIV_CHK: sat_q <= !borrow;
			ST_DIV: begin
				rem_q <= borrow ? sub_a : sub_d[19:0];
				num_q <= {num_q[15:0], !borrow};
			end
			ST_DIV_FIN: scaled_q <= scaled_new;
			ST_FLT_MUL: prod_q   <= mul_p;
			ST_DONE: begin
				if (out_load) begin
					dp_q <= diff_q;
					rs_q <= speed_q;
					ss_q <= scaled_q;
					fs_q <= smooth_q;
					ps_q <= prior_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid         = out_valid_q;
	assign pressure_delta    = dp_q;
	assign root_speed        = rs_q;
	assign corrected_speed   = ss_q;
	assign filtered_airspeed = fs_q;
	assign previous_airspeed = ps_q;

endmodule
`default_nettype wire

[rtl/core/pitot_checker.sv]
`default_nettype none
module pitot_checker
	import pitot_pkg::*;
(
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input wire                  out_valid,
	input wire                  out_ready,
	input wire [17:0]           pressure_delta,
	input wire [15:0]           root_speed,
	input wire [17:0]           corrected_speed,
	input wire [17:0]           filtered_airspeed,
	input wire [17:0]           previous_airspeed
);

	// busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready still high after a word was taken");

	// a stalled result word holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pressure_delta)
			&& $stable(root_speed) && $stable(corrected_speed)
			&& $stable(filtered_airspeed) && $stable(previous_airspeed)))
		else $error("result word changed or dropped while stalled");

	// pressure saturates symmetrically, so the most negative code never shows
	a_pressure_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pressure_delta != PRES_FLOOR))
		else $error("differential pressure outside saturation range");

	// a new result only comes out of a busy sequencer
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the block was idle");

endmodule

bind pitot_airspeed_estimator_top pitot_checker u_pitot_checker (.*);
`default_nettype wire

[bench/pitot_airspeed_estimator_top_test.sv]
`default_nettype none
module pitot_airspeed_estimator_top_test
	import pitot_pkg::*;
();

	// fixed point layout of the block under test
	localparam int PF = 4;
	localparam int SF = 8;
	localparam int ROOT_SHIFT = 2 * SF - (PF + 12);
	localparam longint PRES_LIM = ((longint'(5000) << PF) > 131071) ? 131071 : (longint'(5000) << PF);
	localparam longint SPEED_HI = 131071;
	localparam longint SPEED_LO = -131072;
	localparam longint RAW_SPEED_HI = 65535;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 100;
	localparam int HOLD_CYCLES     = 300;
	localparam int TAIL_CYCLES     = 60;
	localparam int CYCLE_LIMIT     = 400000;

	// one result word, field by field
	typedef struct {
		pres_t   dp;
		rspeed_t rs;
		speed_t  ss;
		speed_t  fs;
		speed_t  ps;
	} airspeed_t;

	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		volt_t                 v;
		logic                  warm;
		bit                    typed;
		airspeed_t             want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic  in_valid = 1'b0;
	logic  in_ready;
	volt_t voltage = '0;
	logic  warmed_up = 1'b0;

	logic    out_valid;
	logic    out_ready = 1'b0;
	pres_t   pressure_delta;
	rspeed_t root_speed;
	speed_t  corrected_speed;
	speed_t  filtered_airspeed;
	speed_t  previous_airspeed;

	pitot_airspeed_estimator_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.voltage           (voltage),
		.warmed_up         (warmed_up),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.pressure_delta    (pressure_delta),
		.root_speed        (root_speed),
		.corrected_speed   (corrected_speed),
		.filtered_airspeed (filtered_airspeed),
		.previous_airspeed (previous_airspeed)
	);

	// shadow copy of the registers
	longint conv_q;
	longint corr_gain_q;
	longint corr_off_q;
	longint filt_gain_q;
	longint cal_gain_q;
	bit     cal_en_q;

	// shadow copy of the running state
	longint cal_offset;
	longint smooth_spd;
	longint prior_spd;

	// expected result words, oldest first
	airspeed_t airspeed_due[$];
	stim_row_t stim_rows[$];

	int mismatches   = 0;
	int results_seen = 0;
	int words_sent   = 0;
	int cfg_writes   = 0;
	int cycle_count  = 0;

	// idling control shared by the sender and the receiver
	bit quiet    = 1'b0;
	bit hold_req = 1'b0;
	int hold_left  = 0;
	int stall_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cycle limit reached with %0d result words still due", airspeed_due.size());
		$display("tb: failure");
		$finish;
	end

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	// weight w (q0.16) on the old value, rounded to nearest with ties up
	function automatic longint mix_q16(input longint w, input longint oldv, input longint newv);
		return (w * oldv + (65536 - w) * newv + 32768) >>> 16;
	endfunction

	function automatic longint unsigned floor_root(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// registers as the block sees a write; unknown indexes fall through
	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_CONV_FACTOR: conv_q = longint'(data[15:0]);
			REG_CORR_GAIN:   corr_gain_q = longint'(data[15:0]);
			REG_CORR_OFFSET: corr_off_q = longint'(soffs_t'(data[15:0]));
			REG_FILTER_GAIN: filt_gain_q = longint'(data[15:0]);
			REG_CAL_GAIN:    cal_gain_q = longint'(data[15:0]);
			REG_CAL_ENABLE:  cal_en_q = data[0];
			REG_INIT_OFFSET: cal_offset = clip(longint'(pres_t'(data)), -PRES_LIM, PRES_LIM);
			default: ;
		endcase
	endtask

	// one voltage word through pressure, offset, root, correction and smoothing
	function automatic airspeed_t predict_airspeed(input volt_t v, input logic warm);
		airspeed_t res;
		longint raw_p;
		longint diff_p;
		longint mag;
		longint num;
		longint scaled;
		longint unsigned rad;
		longint unsigned spd;
		raw_p = ((longint'(v) * 1000) <<< PF) + 4096;
		raw_p = (raw_p >>> 13) - (longint'(2500) <<< PF);
		raw_p = clip(raw_p, -PRES_LIM, PRES_LIM);
		if (cal_en_q && warm)
			cal_offset = clip(mix_q16(cal_gain_q, cal_offset, raw_p), -PRES_LIM, PRES_LIM);
		diff_p = clip(raw_p - cal_offset, -PRES_LIM, PRES_LIM);
		mag = (diff_p < 0) ? -diff_p : diff_p;
		rad = longint'(mag) * conv_q;
		if (ROOT_SHIFT >= 0)
			rad = rad << ROOT_SHIFT;
		else
			rad = rad >> (-ROOT_SHIFT);
		spd = floor_root(rad);
		if (spd > RAW_SPEED_HI)
			spd = RAW_SPEED_HI;
		num = (longint'(spd) - corr_off_q) * 4096;
		// a zero divisor saturates by the sign of the numerator
		if (corr_gain_q == 0)
			scaled = (num > 0) ? SPEED_HI : ((num < 0) ? SPEED_LO : 0);
		else
			scaled = clip(num / corr_gain_q, SPEED_LO, SPEED_HI);
		if (warm) begin
			prior_spd = smooth_spd;
			smooth_spd = clip(mix_q16(filt_gain_q, smooth_spd, scaled), SPEED_LO, SPEED_HI);
		end
		res.dp = pres_t'(diff_p);
		res.rs = rspeed_t'(spd);
		res.ss = speed_t'(scaled);
		res.fs = speed_t'(smooth_spd);
		res.ps = speed_t'(prior_spd);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string name, input logic [17:0] got, input logic [17:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
	endtask

	task automatic check_result();
		airspeed_t want;
		if (airspeed_due.size() == 0) begin
			report_mismatch("result word with nothing expected");
		end else begin
			want = airspeed_due.pop_front();
			check_field("pressure_delta", pressure_delta, want.dp);
			check_field("root_speed", {2'b00, root_speed}, {2'b00, want.rs});
			check_field("corrected_speed", corrected_speed, want.ss);
			check_field("filtered_airspeed", filtered_airspeed, want.fs);
			check_field("previous_airspeed", previous_airspeed, want.ps);
		end
		results_seen++;
	endtask

	// receiver: checks each accepted word, then picks the next ready level
	always @(posedge clk) begin
		if (out_valid && out_ready)
			check_result();
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			// long hold: the block fills up and drops in_ready
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// leaves cfg_valid high; the caller lowers it once the last write is in
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		cfg_writes++;
	endtask

	task automatic send_word(input volt_t v, input logic warm, input bit typed,
			input airspeed_t want);
		airspeed_t guess;
		voltage <= v;
		warmed_up <= warm;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		guess = predict_airspeed(v, warm);
		if (typed)
			airspeed_due.push_back(want);
		else
			airspeed_due.push_back(guess);
		words_sent++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// sender pause until every due word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (airspeed_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = '{kind: ROW_CFG, default: '0};
		row.idx = idx;
		row.data = data;
		stim_rows.push_back(row);
	endtask

	task automatic add_word(input int v, input logic warm);
		stim_row_t row;
		row = '{kind: ROW_WORD, default: '0};
		row.v = volt_t'(v);
		row.warm = warm;
		stim_rows.push_back(row);
	endtask

	task automatic add_word_typed(input int v, input logic warm, input longint dp,
			input longint rs, input longint ss, input longint fs, input longint ps);
		stim_row_t row;
		row = '{kind: ROW_WORD, default: '0};
		row.v = volt_t'(v);
		row.warm = warm;
		row.typed = 1'b1;
		row.want.dp = pres_t'(dp);
		row.want.rs = rspeed_t'(rs);
		row.want.ss = speed_t'(ss);
		row.want.fs = speed_t'(fs);
		row.want.ps = speed_t'(ps);
		stim_rows.push_back(row);
	endtask

	initial begin
		logic [CFG_IDX_W-1:0]  ri;
		logic [CFG_DATA_W-1:0] val;
		int wrote;
		volt_t v;
		logic warm;

		// shadow registers and state as after reset
		conv_q = CONV_FACTOR_RST;
		corr_gain_q = CORR_GAIN_RST;
		corr_off_q = CORR_OFFSET_RST;
		filt_gain_q = FILTER_GAIN_RST;
		cal_gain_q = CAL_GAIN_RST;
		cal_en_q = CAL_ENABLE_RST;
		cal_offset = 0;
		smooth_spd = 0;
		prior_spd = 0;

		// directed table
		// mid-scale word straight after reset: everything zero
		add_word_typed(20480, 1'b0, 0, 0, 0, 0, 0);
		// no conversion, zero divisor, most negative offset
		add_cfg(REG_CONV_FACTOR, 18'd0);
		add_cfg(REG_CORR_GAIN, 18'd0);
		add_cfg(REG_CORR_OFFSET, 18'h08000);
		// over 5 V clips the pressure
		add_word_typed(65535, 1'b0, 80000, 0, 131071, 0, 0);
		add_word_typed(0, 1'b0, -40000, 0, 131071, 0, 0);
		// zero divisor with a negative numerator
		add_cfg(REG_CORR_OFFSET, 18'd1);
		add_word_typed(20480, 1'b0, 0, 0, -131072, 0, 0);
		// zero divisor with a zero numerator
		add_cfg(REG_CORR_OFFSET, 18'd0);
		add_word_typed(20480, 1'b0, 0, 0, 0, 0, 0);
		// initial offset beyond the pressure range, both signs
		add_cfg(REG_INIT_OFFSET, 18'h1FFFF);
		add_word_typed(20480, 1'b0, -80000, 0, 0, 0, 0);
		add_cfg(REG_INIT_OFFSET, 18'h20000);
		add_word_typed(20480, 1'b0, 80000, 0, 0, 0, 0);
		add_word_typed(65535, 1'b0, 80000, 0, 0, 0, 0);
		add_cfg(REG_INIT_OFFSET, 18'd0);
		add_cfg(REG_CONV_FACTOR, 18'd6687);
		add_cfg(REG_CORR_GAIN, 18'd4096);
		// warmed up with full-speed calibration
		add_word(0, 1'b1);
		add_cfg(REG_CAL_GAIN, 18'h0FFFF);
		add_word(40960, 1'b1);
		add_word(65535, 1'b1);
		add_cfg(REG_FILTER_GAIN, 18'h0FFFF);
		add_word(30000, 1'b1);
		add_word(1, 1'b1);
		// calibration off, half-weight smoothing
		add_cfg(REG_FILTER_GAIN, 18'h08000);
		add_cfg(REG_CAL_ENABLE, 18'd0);
		add_word(40960, 1'b1);
		add_word(12345, 1'b0);
		// smallest divisor, largest offset
		add_cfg(REG_CORR_GAIN, 18'd1);
		add_cfg(REG_CORR_OFFSET, 18'h07FFF);
		add_word(40960, 1'b1);
		add_word(20480, 1'b1);
		// largest divisor and factor: the root clips
		add_cfg(REG_CORR_GAIN, 18'h0FFFF);
		add_cfg(REG_CONV_FACTOR, 18'h0FFFF);
		add_word(65535, 1'b1);
		add_word(0, 1'b1);
		// write to an index with no register
		add_cfg(REG_UNUSED, 18'h3FFFF);
		add_word(25000, 1'b1);
		add_cfg(REG_CAL_ENABLE, 18'd1);
		add_cfg(REG_CAL_GAIN, 18'd0);
		add_cfg(REG_FILTER_GAIN, 18'd0);
		add_cfg(REG_CORR_GAIN, 18'd4096);
		add_cfg(REG_CONV_FACTOR, 18'd6687);
		add_cfg(REG_CORR_OFFSET, 18'd0);
		add_cfg(REG_INIT_OFFSET, 18'(80000));
		add_word(20480, 1'b1);
		add_word(20480, 1'b0);

		// reset, once
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the table; registers change only with nothing due
		for (int i = 0; i < stim_rows.size(); i++) begin
			if (stim_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_reg(stim_rows[i].idx, stim_rows[i].data);
				if (i + 1 == stim_rows.size() || stim_rows[i + 1].kind != ROW_CFG)
					cfg_valid <= 1'b0;
			end else begin
				send_word(stim_rows[i].v, stim_rows[i].warm, stim_rows[i].typed,
					stim_rows[i].want);
			end
		end

		// random phases, each with fresh register settings
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			wrote = 0;
			for (int r = 0; r < 8; r++) begin
				ri = r[CFG_IDX_W-1:0];
				if ($urandom_range(0, 1) == 1 || (ri == REG_UNUSED && wrote == 0)) begin
					case (ri)
						REG_CONV_FACTOR: begin
							if ($urandom_range(0, 3) == 0)
								val = {2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535))};
							else
								val = 18'($urandom_range(3000, 12000));
						end
						REG_CORR_GAIN: begin
							if ($urandom_range(0, 7) == 0)
								val = {2'($urandom_range(0, 3)), 16'($urandom_range(0, 1))};
							else if ($urandom_range(0, 7) == 0)
								val = {2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535))};
							else
								val = 18'($urandom_range(1024, 16384));
						end
						REG_CORR_OFFSET: begin
							if ($urandom_range(0, 3) == 0)
								val = {2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535))};
							else
								val = {2'b00, 16'($urandom_range(0, 2048) - 1024)};
						end
						REG_INIT_OFFSET: begin
							if ($urandom_range(0, 1) == 0)
								val = 18'(int'($urandom_range(0, 160000)) - 80000);
							else
								val = 18'($urandom_range(0, 18'h3FFFF));
						end
						default: val = {2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535))};
					endcase
					write_reg(ri, val);
					wrote++;
				end
			end
			cfg_valid <= 1'b0;

			// one phase with no idling, and the last one too
			quiet = (p == 2) || (p == PHASES - 1);
			if (p == 3) begin
				@(negedge clk);
				hold_req = 1'b1;
				@(posedge clk);
			end

			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				if (p == 5 && k == WORDS_PER_PHASE / 2)
					drain_results();
				if ($urandom_range(0, 7) == 0)
					v = volt_t'($urandom_range(0, 65535));
				else
					v = volt_t'($urandom_range(0, 40960));
				// mostly warmed up, with the odd cold word
				warm = ($urandom_range(0, 5) != 0);
				send_word(v, warm, 1'b0, '{default: '0});
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d voltage words and %0d register writes in %0d random phases",
			words_sent, cfg_writes, PHASES);
		$display("%0d result words compared, including a long output hold and an input drain",
			results_seen);
		if (mismatches == 0 && airspeed_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches, %0d result words never came", mismatches,
				airspeed_due.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
rtl/core/pitot_pkg.sv
rtl/core/pitot_airspeed_estimator_top.sv
rtl/core/pitot_checker.sv
bench/pitot_airspeed_estimator_top_test.sv
